### sv/text_console_writer_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the text console writer
// Shared wrappers for the concurrent checks on the console ports.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, masked during reset
`define TCW_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("tcw check failed");

// next-cycle implication, masked during reset
`define TCW_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("tcw check failed");

// next-cycle implication, live during reset
`define TCW_ASSERT_NEXT_ALWAYS(label, clk, lhs, rhs) \
  label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
    else $error("tcw check failed");

`endif

### sv/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg
// Types, constants and helpers shared by the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CELL_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [CHAR_W-1:0] CH_NULL      = 8'd0;

  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 2'd1;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t              operation;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [CELL_W-1:0] make_cell(
    input logic [COLOR_W-1:0] fg,
    input logic [COLOR_W-1:0] bg,
    input logic [CHAR_W-1:0]  ch
  );
    return {bg, fg, ch};
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(
    input logic [COL_W-1:0] c,
    input logic [ROW_W-1:0] r
  );
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c));
  endfunction

endpackage

### sv/tcw_buffer.sv
// ---------------------------------------------------------------------------
// tcw_buffer
// Character cell store: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module tcw_buffer (
  input  logic                     clk,
  input  tcw_pkg::mem_req_t        req,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

### sv/tcw_ctrl.sv
// ---------------------------------------------------------------------------
// tcw_ctrl
// Operation sequencer: cursor, cell writes, scroll copy and fill sweeps.
// ---------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tcw_pkg::item_t              item,
  input  logic [tcw_pkg::COLOR_W-1:0] fg_color,
  input  logic [tcw_pkg::COLOR_W-1:0] bg_color,
  input  logic                        slot_free,
  output logic                        emit,
  output tcw_pkg::result_t            result,
  output tcw_pkg::mem_req_t           mem_req,
  input  logic [tcw_pkg::CELL_W-1:0]  mem_rdata
);
  import tcw_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_IDX   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

  state_t state, state_next;

  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ADDR_W-1:0] idx;
  logic              pend_valid;
  logic [ADDR_W-1:0] pend_addr;
  logic              pend_zero;
  logic [CELL_W-1:0] res_cell;
  logic              res_scroll;

  // put-char datapath
  logic [COL_W-1:0]  clamp_col;
  logic [ROW_W-1:0]  clamp_row;
  logic [COL_W-1:0]  col_inc;
  logic [ROW_W-1:0]  row_inc;
  logic              wrap;
  logic              pc_we;
  logic [ADDR_W-1:0] pc_waddr;
  logic [CELL_W-1:0] pc_wdata;
  logic [COL_W-1:0]  pc_col;
  logic [ROW_W-1:0]  pc_row;
  logic              pc_scroll;
  logic              is_nl;
  logic              is_bs;

  always_comb begin
    clamp_col = (item.col >= COL_W'(COLUMNS)) ? LAST_COL : item.col;
    clamp_row = (item.row >= ROW_W'(ROWS)) ? LAST_ROW : item.row;
    col_inc   = cur_col + COL_W'(1);
    row_inc   = cur_row + ROW_W'(1);
    is_nl     = (item.char_code == CH_NEWLINE);
    is_bs     = (item.char_code == CH_BACKSPACE);
    wrap      = is_nl || (col_inc >= COL_W'(COLUMNS));
    pc_we     = 1'b0;
    pc_waddr  = cell_addr(cur_col, cur_row);
    pc_wdata  = make_cell(fg_color, bg_color, item.char_code);
    pc_col    = cur_col;
    pc_row    = cur_row;
    pc_scroll = 1'b0;
    if (is_bs) begin
      if (cur_col != '0 || cur_row != '0) begin
        if (cur_col == '0) begin
          pc_col = LAST_COL;
          pc_row = cur_row - ROW_W'(1);
        end else begin
          pc_col = cur_col - COL_W'(1);
        end
        pc_we    = 1'b1;
        pc_waddr = cell_addr(pc_col, pc_row);
        pc_wdata = make_cell(fg_color, bg_color, CH_NULL);
      end
    end else begin
      pc_we  = !is_nl;
      pc_col = col_inc;
      if (wrap) begin
        pc_col = '0;
        if (row_inc >= ROW_W'(ROWS)) begin
          pc_row    = LAST_ROW;
          pc_scroll = 1'b1;
        end else begin
          pc_row = row_inc;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (idx == LAST_IDX) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (item.operation)
            OP_PUT:   state_next = pc_scroll ? ST_SCROLL : ST_DONE;
            OP_SET:   state_next = ST_DONE;
            OP_CLEAR: state_next = ST_FILL;
            OP_READ:  state_next = ST_READ;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_READ:   state_next = ST_DONE;
      ST_SCROLL: begin
        if (idx == LAST_IDX) state_next = ST_DONE;
      end
      ST_FILL: begin
        if (idx == LAST_IDX) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_INIT;
    endcase
  end

  // outputs and memory port
  always_comb begin
    in_ready      = (state == ST_IDLE);
    emit          = (state == ST_DONE) && slot_free;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx;
    mem_req.wdata = '0;
    mem_req.re    = 1'b0;
    mem_req.raddr = cell_addr(clamp_col, clamp_row);
    if (pend_valid) begin
      // copy write of the row below, or zero for the bottom row
      mem_req.we    = 1'b1;
      mem_req.waddr = pend_addr;
      mem_req.wdata = pend_zero ? '0 : mem_rdata;
    end else begin
      case (state)
        ST_INIT: mem_req.we = 1'b1;
        ST_FILL: begin
          mem_req.we    = 1'b1;
          mem_req.wdata = make_cell(fg_color, bg_color, CH_SPACE);
        end
        ST_IDLE: begin
          if (in_valid && item.operation == OP_PUT) begin
            mem_req.we    = pc_we;
            mem_req.waddr = pc_waddr;
            mem_req.wdata = pc_wdata;
          end
        end
        default: mem_req.we = 1'b0;
      endcase
    end
    if (state == ST_IDLE && in_valid && item.operation == OP_READ) begin
      mem_req.re = 1'b1;
    end else if (state == ST_SCROLL && idx < COPY_END) begin
      mem_req.re    = 1'b1;
      mem_req.raddr = idx + ROW_STRIDE;
    end
  end

  always_comb begin
    result.cursor_col = cur_col;
    result.cursor_row = cur_row;
    result.cell_data  = res_cell;
    result.scrolled   = res_scroll;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      idx        <= '0;
      cur_col    <= '0;
      cur_row    <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= (state == ST_SCROLL);
      if (state == ST_INIT || state == ST_FILL || state == ST_SCROLL) begin
        idx <= (idx == LAST_IDX) ? '0 : idx + ADDR_W'(1);
      end
      if (state == ST_IDLE && in_valid) begin
        case (item.operation)
          OP_PUT: begin
            cur_col <= pc_col;
            cur_row <= pc_row;
          end
          OP_SET: begin
            cur_col <= clamp_col;
            cur_row <= clamp_row;
          end
          OP_CLEAR: begin
            cur_col <= '0;
            cur_row <= '0;
          end
          default: begin
            cur_col <= cur_col;
            cur_row <= cur_row;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= idx;
    pend_zero <= (idx >= COPY_END);
    if (state == ST_IDLE && in_valid) begin
      res_cell   <= '0;
      res_scroll <= (item.operation == OP_PUT) && pc_scroll;
    end
    if (state == ST_READ) begin
      res_cell <= mem_rdata;
    end
  end

endmodule

### sv/text_console_writer.sv
// Flow: put char and set cursor pass from the take to the DONE state and, once the
//   output register is free, into it on m_axis; read cell goes through READ before DONE;
//   clear and a scroll sweep all 2000 cells before DONE. One transaction at a time:
//   s_axis_tready is low from a take until its result is loaded for m_axis.
// Reset: synchronous; afterwards a clearing pass writes zero to all 2000 cells, one per
//   cycle, with s_axis_tready low; configuration writes are taken throughout.
// ---------------------------------------------------------------------------
// text_console_writer
// 80x25 text console: writes characters at the cursor, wraps, scrolls, moves the cursor, clears
// and reads back cells held in a single-ported-write cell buffer.
// ---------------------------------------------------------------------------
module text_console_writer (
  input  logic        clk,
  input  logic        rst,
  // input transactions
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_code[7:0], col[14:8], row[19:15], zero pad
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  // result transactions
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // cursor_col[6:0], cursor_row[11:7],
                                     // cell_data[27:12], scrolled[28], zero pad
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data
);
  import tcw_pkg::*;

  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  item_t              item;
  result_t            result;
  result_t            out_res;
  mem_req_t           mem_req;
  logic [CELL_W-1:0]  mem_rdata;
  logic               emit;
  logic               slot_free;

  // Colour registers. The host must write them only while the console is idle; the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= 4'hF;
      bg_color <= 4'h0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FG_COLOR: fg_color <= cfg_data;
        REG_BG_COLOR: bg_color <= cfg_data;
        default:      fg_color <= fg_color;  // unmapped index: ignore
      endcase
    end
  end

  // Unpack the input transaction
  always_comb begin
    item.operation = op_t'(s_axis_tuser);
    item.char_code = s_axis_tdata[7:0];
    item.col       = s_axis_tdata[14:8];
    item.row       = s_axis_tdata[19:15];
  end

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .item      (item),
    .fg_color  (fg_color),
    .bg_color  (bg_color),
    .slot_free (slot_free),
    .emit      (emit),
    .result    (result),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // Cell buffer. The sequencer never reads and writes the same cell in one
  // cycle, and the scroll copy reads a row ahead of its writes.
  tcw_buffer u_buffer (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // Output register: the sequencer may take the next transaction while a
  // result still waits here; it only stalls when it has a new result to load.
  assign slot_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res <= result;
    end
  end

  assign m_axis_tdata = {3'b000, out_res.scrolled, out_res.cell_data,
                         out_res.cursor_row, out_res.cursor_col};

endmodule

### sv/tcw_checker.sv
// ---------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the text console writer, bound to the top level.
// ---------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module tcw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  import tcw_pkg::*;

  localparam logic [ROW_W-1:0] BOTTOM_ROW = ROW_W'(ROWS - 1);

  // reset starts the clearing pass: no input taken, no result shown
  `TCW_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !s_axis_tready && !m_axis_tvalid)

  // one transaction at a time: the sequencer is busy right after a take
  `TCW_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a stalled result holds its payload
  `TCW_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // a scroll always leaves the cursor on the bottom row
  `TCW_ASSERT_IMPLY(a_scroll_row, clk, rst, m_axis_tvalid && m_axis_tdata[28], m_axis_tdata[11:7] == BOTTOM_ROW)

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
